/* hw/rtl/meter_serial_frame_parser_assert.svh */
// assertion helpers shared by the parser rtl
`ifndef METER_SERIAL_FRAME_PARSER_ASSERT_SVH
`define METER_SERIAL_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define MSFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define MSFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/msfp_pkg.sv */
`timescale 1ns / 1ps

package msfp_pkg;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MAX_LEN = 1'b0;   // word index of max_frame_length

    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 11'd1000;

    localparam int COUNT_BITS_DEFAULT = 11;

    // framing bytes
    localparam logic [7:0] BYTE_STX   = 8'h02;
    localparam logic [7:0] BYTE_ETX   = 8'h03;
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    localparam logic [7:0] CHECK_OFFSET = 8'h20;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_FRAME_START = 3'd0;
    localparam t_kind KIND_LABEL_CHAR  = 3'd1;
    localparam t_kind KIND_VALUE_CHAR  = 3'd2;
    localparam t_kind KIND_EXTRA_CHAR  = 3'd3;
    localparam t_kind KIND_GROUP_END   = 3'd4;
    localparam t_kind KIND_FRAME_END   = 3'd5;
    localparam t_kind KIND_ABANDON     = 3'd6;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_data;
        logic       ok;
    } t_result;

endpackage

/* hw/rtl/msfp_rx_if.sv */
`timescale 1ns / 1ps

interface msfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/msfp_res_if.sv */
`timescale 1ns / 1ps

interface msfp_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_data;
    logic       ok;

    modport source (output valid, output kind, output char_data, output ok, input ready);
    modport sink   (input valid, input kind, input char_data, input ok, output ready);
endinterface

/* hw/rtl/msfp_apb_regs.sv */
`timescale 1ns / 1ps

module msfp_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [msfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [msfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [msfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [msfp_pkg::CFG_W-1:0]      o_max_len
);
    import msfp_pkg::*;

    logic [CFG_W-1:0] r_max_len;
    logic             w_sel_len;

    // word decode, byte offset ignored
    assign w_sel_len = (paddr[APB_ADDR_W-1] == REG_MAX_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && w_sel_len) begin
            r_max_len <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_len) begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_max_len};
        end
    end

    assign pready    = 1'b1;
    assign o_max_len = r_max_len;

endmodule

/* hw/rtl/msfp_core.sv */
`timescale 1ns / 1ps
`include "meter_serial_frame_parser_assert.svh"

module msfp_core #(
    parameter int COUNT_BITS = msfp_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [7:0]                i_byte,
    input  logic [msfp_pkg::CFG_W-1:0] i_max_len,
    output logic                      o_emit,
    output msfp_pkg::t_result         o_res
);
    import msfp_pkg::*;

    localparam int LW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [LW-1:0] COUNT_MAX = LW'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [1:0] MODE_HUNT  = 2'd0;
    localparam logic [1:0] MODE_FRAME = 2'd1;
    localparam logic [1:0] MODE_GROUP = 2'd2;

    logic [1:0]            r_mode,  n_mode;
    logic [5:0]            r_sum,   n_sum;
    logic [7:0]            r_prev,  n_prev;
    logic [7:0]            r_pprev, n_pprev;
    logic [1:0]            r_body,  n_body;
    logic [1:0]            r_tok,   n_tok;
    logic                  r_in_tok, n_in_tok;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_good,  n_good;
    logic                  r_seen,  n_seen;
    logic                  r_lcr,   n_lcr;

    logic [LW-1:0] w_count_ext;
    logic [LW-1:0] w_len_ext;
    logic [LW-1:0] w_limit;
    logic [5:0]    w_diff;
    logic [7:0]    w_check;
    logic          w_group_ok;

    assign w_count_ext = LW'(r_count);
    assign w_len_ext   = LW'(i_max_len);
    assign w_limit     = (w_len_ext < COUNT_MAX) ? w_len_ext : COUNT_MAX;

    // checksum over the body less its last two bytes
    assign w_diff     = r_sum - r_prev[5:0] - r_pprev[5:0];
    assign w_check    = {2'b00, w_diff} + CHECK_OFFSET;
    assign w_group_ok = r_body[1] && r_tok[1] && (w_check == r_prev);

    always_comb begin
        n_mode   = r_mode;
        n_sum    = r_sum;
        n_prev   = r_prev;
        n_pprev  = r_pprev;
        n_body   = r_body;
        n_tok    = r_tok;
        n_in_tok = r_in_tok;
        n_count  = r_count;
        n_good   = r_good;
        n_seen   = r_seen;
        n_lcr    = r_lcr;
        o_emit   = 1'b0;
        o_res    = '0;

        unique case (r_mode) inside
            MODE_FRAME, MODE_GROUP: begin
                if (i_byte == BYTE_ETX) begin
                    n_mode     = MODE_HUNT;
                    o_emit     = 1'b1;
                    o_res.kind = KIND_FRAME_END;
                    o_res.ok   = r_seen && r_good && r_lcr;
                end else if (w_count_ext >= w_limit) begin
                    n_mode     = MODE_HUNT;
                    o_emit     = 1'b1;
                    o_res.kind = KIND_ABANDON;
                end else begin
                    n_count = r_count + 1'b1;
                    if (r_mode == MODE_FRAME) begin
                        n_lcr = 1'b0;
                        if (i_byte == BYTE_LF) begin
                            n_mode   = MODE_GROUP;
                            n_sum    = '0;
                            n_prev   = '0;
                            n_pprev  = '0;
                            n_body   = '0;
                            n_tok    = '0;
                            n_in_tok = 1'b0;
                        end
                    end else if (i_byte == BYTE_CR) begin
                        n_seen     = 1'b1;
                        n_good     = r_good && w_group_ok;
                        n_mode     = MODE_FRAME;
                        n_lcr      = 1'b1;
                        o_emit     = 1'b1;
                        o_res.kind = KIND_GROUP_END;
                        o_res.ok   = w_group_ok;
                    end else begin
                        n_sum   = r_sum + i_byte[5:0];
                        n_pprev = r_prev;
                        n_prev  = i_byte;
                        if (!r_body[1]) begin
                            n_body = r_body + 2'd1;
                        end
                        if (i_byte == BYTE_SPACE) begin
                            n_in_tok = 1'b0;
                        end else begin
                            // first char of a token bumps the token index
                            if (!r_in_tok) begin
                                n_in_tok = 1'b1;
                                if (r_tok != 2'd3) begin
                                    n_tok = r_tok + 2'd1;
                                end
                            end
                            o_emit          = 1'b1;
                            o_res.kind      = {1'b0, n_tok};
                            o_res.char_data = i_byte;
                        end
                    end
                end
            end
            default: begin
                // hunting, unused code behaves the same
                if (i_byte == BYTE_STX) begin
                    n_mode     = MODE_FRAME;
                    n_count    = '0;
                    n_good     = 1'b1;
                    n_seen     = 1'b0;
                    n_lcr      = 1'b0;
                    o_emit     = 1'b1;
                    o_res.kind = KIND_FRAME_START;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_HUNT;
            r_sum    <= '0;
            r_prev   <= '0;
            r_pprev  <= '0;
            r_body   <= '0;
            r_tok    <= '0;
            r_in_tok <= 1'b0;
            r_count  <= '0;
            r_good   <= 1'b1;
            r_seen   <= 1'b0;
            r_lcr    <= 1'b0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_sum    <= n_sum;
            r_prev   <= n_prev;
            r_pprev  <= n_pprev;
            r_body   <= n_body;
            r_tok    <= n_tok;
            r_in_tok <= n_in_tok;
            r_count  <= n_count;
            r_good   <= n_good;
            r_seen   <= n_seen;
            r_lcr    <= n_lcr;
        end
    end

    `MSFP_ASSERT_NOW(a_char_only_in_group, i_clk, i_rst_n, i_fire && o_emit && (o_res.kind == KIND_LABEL_CHAR || o_res.kind == KIND_VALUE_CHAR || o_res.kind == KIND_EXTRA_CHAR), r_mode == MODE_GROUP, "token char outside a group")
    `MSFP_ASSERT_NOW(a_ok_only_on_verdict, i_clk, i_rst_n, o_emit && o_res.ok, o_res.kind == KIND_GROUP_END || o_res.kind == KIND_FRAME_END, "ok set on a kind without verdict")
    `MSFP_ASSERT_NEXT(a_group_end_leaves_group, i_clk, i_rst_n, i_fire && o_emit && o_res.kind == KIND_GROUP_END, r_mode == MODE_FRAME && r_lcr && r_seen, "group end did not return to frame")

endmodule

/* hw/rtl/meter_serial_frame_parser.sv */
`timescale 1ns / 1ps
`include "meter_serial_frame_parser_assert.svh"

// byte-stream decoder for historic-mode meter telemetry frames. each received
// byte goes in on i_rx; frame start, token characters (tagged label, value or
// extra), group end with checksum verdict, frame end with frame verdict and
// frame abandon come out on o_res, at most one request per byte. while o_res is
// not stalled one byte is taken every cycle: the decode is a single pass of logic
// between the input register and the result register, so throughput is one byte
// per clock; a byte's result is captured in the result register and offered on
// o_res from there. a result left waiting on o_res holds the decode, and the
// input closes once the input register is full as well. max_frame_length sits at
// apb address 0 and should be changed only while the parser is idle.
// there is no clearing pass after reset.
module meter_serial_frame_parser #(
    parameter int COUNT_BITS = msfp_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    msfp_rx_if.sink                         i_rx,
    msfp_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [msfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [msfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import msfp_pkg::*;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // result register
    logic       r_out_vld;
    t_result    r_out;

    logic             w_proc;
    logic             w_emit;
    t_result          w_res;
    logic [CFG_W-1:0] w_max_len;

    msfp_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (w_max_len)
    );

    // a held byte is decoded once the result register has room
    assign w_proc = r_in_vld && (!r_out_vld || o_res.ready);

    // input side is open while empty or while the held byte moves on this cycle
    assign i_rx.ready = !r_in_vld || w_proc;

    msfp_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_proc),
        .i_byte    (r_in_byte),
        .i_max_len (w_max_len),
        .o_emit    (w_emit),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // result register: loads on a decoded byte, drains on downstream ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc) begin
            r_out_vld <= w_emit;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.kind      = r_out.kind;
    assign o_res.char_data = r_out.char_data;
    assign o_res.ok        = r_out.ok;

    `MSFP_ASSERT_NEXT(a_held_byte_kept, i_clk, i_rst_n, r_in_vld && !w_proc, r_in_vld && $stable(r_in_byte), "held input byte lost")
    `MSFP_ASSERT_NOW(a_take_only_when_moving, i_clk, i_rst_n, i_rx.valid && i_rx.ready && r_in_vld, w_proc, "input byte overwritten")
    `MSFP_ASSERT_NEXT(a_emit_reaches_output, i_clk, i_rst_n, w_proc && w_emit, r_out_vld, "decoded request dropped")

endmodule

/* dv/tb_meter_serial_frame_parser.sv */
`timescale 1ns / 1ps

module tb_meter_serial_frame_parser;
    import msfp_pkg::*;

    localparam int COUNT_BITS = COUNT_BITS_DEFAULT;
    localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
    localparam int CFG_MAX = (1 << CFG_W) - 1;
    // register word indexes and their byte addresses
    localparam int REG_SPARE = 1;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LEN = APB_ADDR_W'(4 * int'(REG_MAX_LEN));
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = APB_ADDR_W'(4 * REG_SPARE);
    // margin after the last owed result so that nothing is left in flight
    localparam int SETTLE_CYCLES = 8;
    localparam int BYTES_PER_SETTING = 250;

    typedef enum logic [1:0] {MODE_HUNT, MODE_FRAME, MODE_GROUP} t_parse_mode;
    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} t_stall_style;

    // one directed byte, with its result typed in where it is obvious
    typedef struct {
        logic [7:0] rx_val;
        bit         typed;
        bit         has_res;
        t_result    res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    msfp_rx_if  rx_if();
    msfp_res_if res_if();

    meter_serial_frame_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // parser state as the testbench sees it
    t_parse_mode           parse_mode;
    logic [5:0]            group_sum;
    logic [7:0]            last_body;
    logic [7:0]            second_last_body;
    logic [1:0]            body_len;
    logic [1:0]            token_count;
    logic                  inside_token;
    logic [COUNT_BITS-1:0] frame_bytes;
    logic                  frame_ok_so_far;
    logic                  any_group;
    logic                  prev_was_cr;
    logic [CFG_W-1:0]      max_len_cfg;

    // results the parser owes us, oldest first
    t_result expected_results[$];
    t_result oldest_result;

    // directed stimulus table
    t_stim_row directed_rows[$];

    int fail_count = 0;
    int bytes_sent = 0;
    int live_bytes = 0;
    int settings_tried = 0;
    int kind_count[8];
    int good_groups = 0;
    int good_frames = 0;
    int burst_left = 0;
    int calm_bursts = 0;

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // walk one byte through the decode, returning the result it causes
    task automatic decode_byte(input logic [7:0] rx_val, output bit has, output t_result r);
        int         limit;
        logic [5:0] diff;
        logic [7:0] check;
        logic       group_ok;
        has = 1'b0;
        r = '0;
        limit = (int'(max_len_cfg) < COUNT_MAX) ? int'(max_len_cfg) : COUNT_MAX;

        // hunting: only stx opens a frame
        if (parse_mode != MODE_FRAME && parse_mode != MODE_GROUP) begin
            if (rx_val == BYTE_STX) begin
                parse_mode = MODE_FRAME;
                frame_bytes = '0;
                frame_ok_so_far = 1'b1;
                any_group = 1'b0;
                prev_was_cr = 1'b0;
                has = 1'b1;
                r.kind = KIND_FRAME_START;
            end
            return;
        end

        // etx closes the frame at once, even inside a group
        if (rx_val == BYTE_ETX) begin
            parse_mode = MODE_HUNT;
            has = 1'b1;
            r.kind = KIND_FRAME_END;
            r.ok = any_group && frame_ok_so_far && prev_was_cr;
            return;
        end

        // frame already at its length limit: drop the byte and resume hunting
        if (int'(frame_bytes) >= limit) begin
            parse_mode = MODE_HUNT;
            has = 1'b1;
            r.kind = KIND_ABANDON;
            return;
        end
        frame_bytes = frame_bytes + 1'b1;

        // between groups everything but lf is skipped
        if (parse_mode == MODE_FRAME) begin
            prev_was_cr = 1'b0;
            if (rx_val == BYTE_LF) begin
                parse_mode = MODE_GROUP;
                group_sum = '0;
                last_body = '0;
                second_last_body = '0;
                body_len = '0;
                token_count = '0;
                inside_token = 1'b0;
            end
            return;
        end

        // cr ends the group: checksum covers the body less its last two bytes
        if (rx_val == BYTE_CR) begin
            diff = group_sum - last_body[5:0] - second_last_body[5:0];
            check = {2'b00, diff} + CHECK_OFFSET;
            group_ok = (body_len >= 2'd2) && (token_count >= 2'd2) && (check == last_body);
            any_group = 1'b1;
            if (!group_ok) begin
                frame_ok_so_far = 1'b0;
            end
            parse_mode = MODE_FRAME;
            prev_was_cr = 1'b1;
            has = 1'b1;
            r.kind = KIND_GROUP_END;
            r.ok = group_ok;
            return;
        end

        // body byte, stx and lf included
        group_sum = group_sum + rx_val[5:0];
        second_last_body = last_body;
        last_body = rx_val;
        if (body_len < 2'd2) begin
            body_len = body_len + 1'b1;
        end
        if (rx_val == BYTE_SPACE) begin
            inside_token = 1'b0;
            return;
        end
        if (!inside_token) begin
            inside_token = 1'b1;
            if (token_count < 2'd3) begin
                token_count = token_count + 1'b1;
            end
        end
        has = 1'b1;
        r.char_data = rx_val;
        case (token_count)
            2'd1: begin
                r.kind = KIND_LABEL_CHAR;
            end
            2'd2: begin
                r.kind = KIND_VALUE_CHAR;
            end
            default: begin
                r.kind = KIND_EXTRA_CHAR;
            end
        endcase
    endtask

    function automatic t_stim_row row_of(input logic [7:0] rx_val, input bit typed,
                                         input bit has, input t_kind kind,
                                         input logic [7:0] ch, input logic ok);
        t_stim_row row;
        row.rx_val = rx_val;
        row.typed = typed;
        row.has_res = has;
        row.res.kind = kind;
        row.res.char_data = ch;
        row.res.ok = ok;
        return row;
    endfunction

    task automatic add_row(input t_stim_row row);
        directed_rows = {directed_rows, row};
    endtask

    function automatic logic [7:0] pick_byte_not(input logic [7:0] x0, input logic [7:0] x1,
                                                 input logic [7:0] x2);
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while (v == x0 || v == x1 || v == x2);
        return v;
    endfunction

    // predict, queue the result, then offer the byte in bursts with random gaps
    task automatic send_row(input t_stim_row row);
        bit      has;
        t_result r;
        int      gap;
        if (parse_mode != MODE_HUNT || row.rx_val == BYTE_STX) begin
            live_bytes++;
        end
        decode_byte(row.rx_val, has, r);
        if (row.typed) begin
            has = row.has_res;
            r = row.res;
        end
        if (has) begin
            expected_results = {expected_results, r};
        end

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (calm_bursts > 0) begin
                calm_bursts--;
            end else if ($urandom_range(0, 15) == 0) begin
                // a stretch of back-to-back bytes
                calm_bursts = $urandom_range(3, 10);
            end else begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    rx_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        burst_left--;
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= row.rx_val;
        do begin
            @(posedge i_clk);
        end while (!rx_if.ready);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] rx_val);
        send_row(row_of(rx_val, 1'b0, 1'b0, KIND_FRAME_START, 8'h00, 1'b0));
    endtask

    // lf, label, maybe value and extra token, mostly space and checksum, then cr or etx
    task automatic send_group(input bit compact, output bit frame_closed);
        logic [7:0] body[$];
        int         sum;
        logic [7:0] csum;
        int         ending;
        frame_closed = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2)) body = {body, BYTE_SPACE};
        end
        repeat ($urandom_range(1, compact ? 2 : 8)) begin
            body = {body, pick_byte_not(BYTE_ETX, BYTE_CR, BYTE_SPACE)};
        end
        // now and then the value token is missing
        if ($urandom_range(0, 11) != 0) begin
            repeat ($urandom_range(0, 4) == 0 ? 2 : 1) body = {body, BYTE_SPACE};
            repeat ($urandom_range(1, compact ? 2 : 10)) begin
                body = {body, pick_byte_not(BYTE_ETX, BYTE_CR, BYTE_SPACE)};
            end
            if ($urandom_range(0, 11) == 0) begin
                body = {body, BYTE_SPACE};
                repeat ($urandom_range(1, 4)) begin
                    body = {body, pick_byte_not(BYTE_ETX, BYTE_CR, BYTE_SPACE)};
                end
            end
        end
        if ($urandom_range(0, 19) != 0) begin
            sum = 0;
            foreach (body[i]) begin
                sum += body[i];
            end
            csum = 8'((sum & 'h3F)) + CHECK_OFFSET;
            // corrupt the low bits only, so the checksum never turns into etx or cr
            if ($urandom_range(0, 9) == 0) begin
                csum = csum ^ {3'b000, 5'($urandom_range(1, 31))};
            end
            body = {body, BYTE_SPACE};
            body = {body, csum};
        end

        send_byte(BYTE_LF);
        foreach (body[i]) begin
            send_byte(body[i]);
        end
        ending = $urandom_range(0, 39);
        if (ending == 0) begin
            // etx inside the group
            send_byte(BYTE_ETX);
            frame_closed = 1'b1;
        end else if (ending != 1) begin
            send_byte(BYTE_CR);
        end
        // otherwise the group stays open and the next lf lands in its body
    endtask

    // stx and filler without etx, one byte past the limit and a little more
    task automatic send_runaway();
        send_byte(BYTE_STX);
        repeat (int'(max_len_cfg) + $urandom_range(1, 3)) send_byte(pick_byte_not(BYTE_ETX, BYTE_STX, BYTE_STX));
    endtask

    task automatic send_frame(input bit compact);
        bit closed;
        // line noise while hunting
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(pick_byte_not(BYTE_STX, BYTE_STX, BYTE_STX));
        end
        if (max_len_cfg <= 100 && $urandom_range(0, 9) == 0) begin
            send_runaway();
            return;
        end
        send_byte(BYTE_STX);
        repeat ($urandom_range(0, compact ? 2 : 4)) begin
            if ($urandom_range(0, 6) == 0) begin
                send_byte(pick_byte_not(BYTE_ETX, BYTE_LF, BYTE_LF));
            end
            send_group(compact, closed);
            if (closed) begin
                return;
            end
        end
        // a stray byte between the last cr and etx spoils the frame
        if ($urandom_range(0, 11) == 0) begin
            send_byte(pick_byte_not(BYTE_ETX, BYTE_LF, BYTE_LF));
        end
        send_byte(BYTE_ETX);
    endtask

    // stop sending, wait for every owed result and let the pipeline empty
    task automatic drain_parser();
        rx_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // bus idle before the next transfer
        @(posedge i_clk);
    endtask

    task automatic verify_max_len_readback();
        logic [APB_DATA_W-1:0] data;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_MAX_LEN;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (data !== APB_DATA_W'(max_len_cfg)) begin
            $error("max_frame_length: expected %0d, got %0d", max_len_cfg, data);
            fail_count++;
        end
    endtask

    task automatic set_max_len(input logic [CFG_W-1:0] len);
        drain_parser();
        apb_write(ADDR_MAX_LEN, APB_DATA_W'(len));
        max_len_cfg = len;
        settings_tried++;
        verify_max_len_readback();
    endtask

    // result side: ready follows a stall pattern that is redrawn at random
    initial begin
        int           tick;
        t_stall_style style;
        tick = 0;
        style = STALL_NONE;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (tick % 200 == 0) begin
                style = t_stall_style'($urandom_range(0, 3));
            end
            case (style)
                STALL_NONE: begin
                    res_if.ready <= 1'b1;
                end
                STALL_RANDOM: begin
                    res_if.ready <= ($urandom_range(0, 9) < 7);
                end
                STALL_PERIODIC: begin
                    res_if.ready <= (tick % 5 != 0);
                end
                default: begin
                    // long stalls
                    res_if.ready <= ((tick % 40) < 28);
                end
            endcase
        end
    end

    // compare each accepted result against the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with none owed: kind %0d char %02h ok %0d",
                       res_if.kind, res_if.char_data, res_if.ok);
                fail_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (res_if.kind !== oldest_result.kind) begin
                    $error("kind: expected %0d, got %0d", oldest_result.kind, res_if.kind);
                    fail_count++;
                end
                if (res_if.char_data !== oldest_result.char_data) begin
                    $error("char_data: expected %02h, got %02h",
                           oldest_result.char_data, res_if.char_data);
                    fail_count++;
                end
                if (res_if.ok !== oldest_result.ok) begin
                    $error("ok: expected %0d, got %0d", oldest_result.ok, res_if.ok);
                    fail_count++;
                end
                kind_count[oldest_result.kind]++;
                if (oldest_result.kind == KIND_GROUP_END && oldest_result.ok) begin
                    good_groups++;
                end
                if (oldest_result.kind == KIND_FRAME_END && oldest_result.ok) begin
                    good_frames++;
                end
            end
        end
    end

    // hard stop if the parser hangs
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int len_plan[6];
        int phase_start;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;

        parse_mode = MODE_HUNT;
        group_sum = '0;
        last_body = '0;
        second_last_body = '0;
        body_len = '0;
        token_count = '0;
        inside_token = 1'b0;
        frame_bytes = '0;
        frame_ok_so_far = 1'b1;
        any_group = 1'b0;
        prev_was_cr = 1'b0;
        max_len_cfg = MAX_LEN_RESET;
        foreach (kind_count[k]) begin
            kind_count[k] = 0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        verify_max_len_readback();

        // dropped while hunting, then a well-formed group "A  1 R" and etx
        add_row(row_of(8'h41, 1, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_STX, 1, 1, KIND_FRAME_START, 8'h00, 1'b0));
        // stx inside a frame outside a group is skipped
        add_row(row_of(BYTE_STX, 1, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_LF, 1, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(8'h41, 0, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_SPACE, 0, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_SPACE, 0, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(8'h31, 0, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_SPACE, 0, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(8'h52, 0, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_CR, 0, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_ETX, 0, 0, KIND_FRAME_START, 8'h00, 1'b0));
        // extreme chars, lf and stx as body bytes, single-token group fails
        add_row(row_of(BYTE_STX, 1, 1, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_LF, 1, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(8'hFF, 1, 1, KIND_LABEL_CHAR, 8'hFF, 1'b0));
        add_row(row_of(8'h00, 1, 1, KIND_LABEL_CHAR, 8'h00, 1'b0));
        add_row(row_of(BYTE_LF, 1, 1, KIND_LABEL_CHAR, BYTE_LF, 1'b0));
        add_row(row_of(BYTE_STX, 1, 1, KIND_LABEL_CHAR, BYTE_STX, 1'b0));
        add_row(row_of(BYTE_CR, 1, 1, KIND_GROUP_END, 8'h00, 1'b0));
        // empty group fails
        add_row(row_of(BYTE_LF, 1, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_CR, 1, 1, KIND_GROUP_END, 8'h00, 1'b0));
        // etx inside an open group: no group end, frame verdict zero
        add_row(row_of(BYTE_LF, 1, 0, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_ETX, 1, 1, KIND_FRAME_END, 8'h00, 1'b0));
        // frame without any group
        add_row(row_of(BYTE_STX, 1, 1, KIND_FRAME_START, 8'h00, 1'b0));
        add_row(row_of(BYTE_ETX, 1, 1, KIND_FRAME_END, 8'h00, 1'b0));
        foreach (directed_rows[i]) begin
            send_row(directed_rows[i]);
        end

        // writes to a register index past the first are ignored
        drain_parser();
        apb_write(ADDR_SPARE, $urandom());
        verify_max_len_readback();

        // random traffic under several length limits, extremes included
        len_plan[0] = MAX_LEN_RESET;
        len_plan[1] = CFG_MAX;
        len_plan[2] = 1;
        len_plan[3] = 2;
        len_plan[4] = 37;
        len_plan[5] = $urandom_range(1, CFG_MAX);
        foreach (len_plan[p]) begin
            set_max_len(CFG_W'(len_plan[p]));
            phase_start = live_bytes;
            while (live_bytes - phase_start < BYTES_PER_SETTING) begin
                send_frame(max_len_cfg < 64);
            end
        end

        drain_parser();
        $display("covered %0d bytes, %0d of them inside frames, under %0d length settings",
                 bytes_sent, live_bytes, settings_tried);
        $display("frames %0d started %0d ended %0d good %0d abandoned, groups %0d (%0d good)",
                 kind_count[KIND_FRAME_START], kind_count[KIND_FRAME_END], good_frames,
                 kind_count[KIND_ABANDON], kind_count[KIND_GROUP_END], good_groups);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* meter_serial_frame_parser.f */
+incdir+hw/rtl
hw/rtl/msfp_pkg.sv
hw/rtl/msfp_rx_if.sv
hw/rtl/msfp_res_if.sv
hw/rtl/msfp_apb_regs.sv
hw/rtl/msfp_core.sv
hw/rtl/meter_serial_frame_parser.sv
dv/tb_meter_serial_frame_parser.sv
